// ----- rtl/sha256_stream_hash_top_macros.svh -----
// Assertion macros shared by the hasher's checker.
`ifndef SHA256_STREAM_HASH_TOP_MACROS_SVH
`define SHA256_STREAM_HASH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hasher check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hasher check failed");

`endif

// ----- rtl/sha_pkg.sv -----
// Shared types, constants and sigma functions of the SHA-256 hasher.
package sha_pkg;

    typedef logic [31:0] chain_t [8];

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Control from the sequencer to the schedule and round datapaths.
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       expand;
        logic       vars_init;
        logic       round_step;
        logic       chain_add;
        logic       chain_init;
        logic [5:0] round_idx;
    } sha_ctl_t;

    localparam chain_t INIT_WORDS = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/sha_msg_sched.sv -----
// Block buffer and message schedule: a 16-word shift line filled a byte at a time.
module sha_msg_sched
    import sha_pkg::*;
(
    input  logic        clk,
    input  sha_ctl_t    ctl,
    output logic [31:0] sched_word
);

    logic [31:0] sched_reg  [16];
    logic [31:0] sched_next [16];
    logic [31:0] new_word;

    assign new_word = sched_reg[0] + small_sigma0(sched_reg[1]) + sched_reg[9]
                    + small_sigma1(sched_reg[14]);
    assign sched_word = sched_reg[0];

    always_comb
    begin
        sched_next = sched_reg;
        if (ctl.shift_byte)
        begin
            // shift the whole block left by one byte, new byte at the tail
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = {sched_reg[i][23:0], sched_reg[i + 1][31:24]};
            end
            sched_next[15] = {sched_reg[15][23:0], ctl.byte_val};
        end
        else if (ctl.expand)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[15] = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
    end

endmodule

// ----- rtl/sha_core.sv -----
// Round unit: working variables, one compression round per cycle, chaining words.
module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_ctl_t    ctl,
    input  logic [31:0] sched_word,
    output chain_t      chain
);

    chain_t      chain_reg;
    chain_t      chain_next;
    logic [31:0] vars_reg  [8];
    logic [31:0] vars_next [8];
    logic [31:0] t1;
    logic [31:0] t2;

    assign t1 = vars_reg[7] + big_sigma1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + ROUND_K[ctl.round_idx] + sched_word;
    assign t2 = big_sigma0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        vars_next = vars_reg;
        if (ctl.vars_init)
        begin
            vars_next = chain_reg;
        end
        else if (ctl.round_step)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctl.chain_init)
        begin
            chain_next = INIT_WORDS;
        end
        else if (ctl.chain_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_WORDS;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

// ----- rtl/sha_seq.sv -----
// Sequencer: byte intake, padding feed, round counting and digest output register.
module sha_seq
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     msg_valid,
    output logic     msg_stall,
    input  sha_in_t  msg,
    output logic     digest_valid,
    input  logic     digest_stall,
    output sha_out_t digest,
    input  chain_t   chain,
    output sha_ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PAD_MARK = 4'd1;
    localparam logic [3:0] S_PAD_ZERO = 4'd2;
    localparam logic [3:0] S_PAD_LEN  = 4'd3;
    localparam logic [3:0] S_INIT     = 4'd4;
    localparam logic [3:0] S_ROUND    = 4'd5;
    localparam logic [3:0] S_ADD      = 4'd6;
    localparam logic [3:0] S_EMIT     = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_ZERO = 2'd2;
    localparam logic [1:0] RET_OUT  = 2'd3;

    localparam logic [5:0] FILL_FULL = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] ROUND_END = 6'd63;
    localparam logic [2:0] WORD_END  = 3'd7;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oword_reg, oword_next;
    logic [2:0]  oidx_inc;
    logic [5:0]  fill_inc;
    logic [7:0]  len_byte;

    assign oidx_inc = oidx_reg + 3'd1;
    assign fill_inc = fill_reg + 6'd1;
    // length bytes go out most significant first while fill runs 56..63
    assign len_byte = 8'(bitlen_reg >> {~fill_reg[2:0], 3'b000});

    assign msg_stall             = (state_reg != S_IDLE);
    assign digest_valid          = ovalid_reg;
    assign digest.digest_word    = oword_reg;
    assign digest.word_index     = oidx_reg;
    assign digest.last_word      = (oidx_reg == WORD_END);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        fill_next   = fill_reg;
        bitlen_next = bitlen_reg;
        round_next  = round_reg;
        oidx_next   = oidx_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        ctl            = '0;
        ctl.round_idx  = round_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.has_byte)
                    begin
                        ctl.shift_byte = 1'b1;
                        ctl.byte_val   = msg.data_byte;
                        fill_next      = fill_inc;
                        bitlen_next    = bitlen_reg + 64'd8;
                    end
                    if (msg.has_byte && fill_reg == FILL_FULL)
                    begin
                        state_next = S_INIT;
                        ret_next   = msg.last ? RET_PAD : RET_IDLE;
                    end
                    else if (msg.last)
                    begin
                        state_next = S_PAD_MARK;
                    end
                end
            end
            S_PAD_MARK:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = PAD_MARK;
                fill_next      = fill_inc;
                if (fill_reg == FILL_FULL)
                begin
                    state_next = S_INIT;
                    ret_next   = RET_ZERO;
                end
                else
                begin
                    state_next = S_PAD_ZERO;
                end
            end
            S_PAD_ZERO:
            begin
                // stop at 56 only when counting up within the length block
                if (fill_reg == LEN_START)
                begin
                    state_next = S_PAD_LEN;
                end
                else
                begin
                    ctl.shift_byte = 1'b1;
                    fill_next      = fill_inc;
                    if (fill_reg == FILL_FULL)
                    begin
                        state_next = S_INIT;
                        ret_next   = RET_ZERO;
                    end
                end
            end
            S_PAD_LEN:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = len_byte;
                fill_next      = fill_inc;
                if (fill_reg == FILL_FULL)
                begin
                    state_next = S_INIT;
                    ret_next   = RET_OUT;
                end
            end
            S_INIT:
            begin
                ctl.vars_init = 1'b1;
                round_next    = '0;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                ctl.round_step = 1'b1;
                ctl.expand     = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == ROUND_END)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                ctl.chain_add = 1'b1;
                case (ret_reg)
                    RET_IDLE: state_next = S_IDLE;
                    RET_PAD:  state_next = S_PAD_MARK;
                    RET_ZERO: state_next = S_PAD_ZERO;
                    RET_OUT:  state_next = S_EMIT;
                    default:  state_next = S_IDLE;
                endcase
                oidx_next = '0;
            end
            S_EMIT:
            begin
                oword_next  = chain[oidx_reg];
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!digest_stall)
                begin
                    if (oidx_reg == WORD_END)
                    begin
                        // digest drained: reinitialize for the next message
                        ovalid_next    = 1'b0;
                        oidx_next      = '0;
                        ctl.chain_init = 1'b1;
                        bitlen_next    = '0;
                        fill_next      = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        oidx_next  = oidx_inc;
                        oword_next = chain[oidx_inc];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= RET_IDLE;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            round_reg  <= '0;
            oidx_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            round_reg  <= round_next;
            oidx_reg   <= oidx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
    end

endmodule

// ----- rtl/sha256_stream_hash_top.sv -----
// Top level of the SHA-256 stream hasher.
//
// Message channel (msg_valid / msg_stall / msg): one beat carries one byte
// (has_byte) and an end-of-message mark (last). A beat with neither is a no-op.
// Digest channel (digest_valid / digest_stall / digest): eight beats per
// message, word_index 0..7, big-endian words, last_word on the eighth.
// Timing: a byte that does not fill the block is taken with no stall; one
// that completes a 64-byte block starts compression: one round per cycle
// over 64 rounds in the shared round unit, after a load, then a chaining
// add. On last, padding is fed byte-serially through the block buffer up to
// the next block end, one byte per cycle but paused while a block compresses
// and before the length field. Each padded block (one or two) is compressed
// likewise; then the output register is loaded and the digest words follow.
// msg_stall is high after a beat that fills a block until it is compressed,
// and after a last beat until the eighth digest beat is taken. A stalled
// digest beat holds its word; the hasher waits as long as digest_stall is high.
// Reset sets the chaining words to the initial hash values and clears the
// length and fill counters; no clearing pass is needed.
module sha256_stream_hash_top
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     msg_valid,
    output logic     msg_stall,
    input  sha_in_t  msg,
    output logic     digest_valid,
    input  logic     digest_stall,
    output sha_out_t digest
);

    sha_ctl_t    ctl;
    chain_t      chain;
    logic [31:0] sched_word;

    sha_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest),
        .chain        (chain),
        .ctl          (ctl)
    );

    sha_msg_sched u_sched (
        .clk        (clk),
        .ctl        (ctl),
        .sched_word (sched_word)
    );

    sha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sched_word (sched_word),
        .chain      (chain)
    );

endmodule

// ----- rtl/sha_check.sv -----
// Port-level checker for the SHA-256 hasher, bound to the top level.
`include "sha256_stream_hash_top_macros.svh"

module sha_check
    import sha_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     msg_stall,
    input logic     digest_valid,
    input logic     digest_stall,
    input sha_out_t digest
);

    // no new message beat is taken while a digest is being delivered
    `SHA_ASSERT_SAME(a_out_blocks_in, digest_valid, msg_stall)
    // last_word marks word seven and nothing else
    `SHA_ASSERT_SAME(a_last_word_idx, digest_valid, digest.last_word == (digest.word_index == 3'd7))
    // after the final word is taken the channel goes quiet
    `SHA_ASSERT_NEXT(a_drain_done, digest_valid && !digest_stall && digest.last_word, !digest_valid)
    // a stalled digest beat holds
    `SHA_ASSERT_NEXT(a_hold, digest_valid && digest_stall, digest_valid && $stable(digest))

endmodule

bind sha256_stream_hash_top sha_check u_check (.*);
